FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/msqh_pkg.sv
// ----------------------------------------------------------------------------
// msqh_pkg
// Types and constants shared by the mid-square hash table modules.
// ----------------------------------------------------------------------------
package msqh_pkg;

    localparam int SLOTS  = 10;
    localparam int SLOT_W = 4;
    localparam int KEY_W  = 16;
    localparam int SQ_W   = 32;
    localparam int DIGITS = 10;

    // ceil(2^35 / 10): exact quotient by ten for any 32-bit value
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_DELETE = 2'd1;
    localparam logic [1:0] FN_SEARCH = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DELETED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [KEY_W-1:0]  key_t;

    typedef struct packed {
        logic       start;
        logic [1:0] func;
        key_t       key;
        slot_t      home;
    } probe_req_t;

    typedef struct packed {
        logic       done;
        logic [2:0] status;
        slot_t      slot;
    } probe_rsp_t;

endpackage

FILE: rtl/core/midsquare_hash_linear_probe_table.sv
// ----------------------------------------------------------------------------
// midsquare_hash_linear_probe_table
// Ten-slot hash table: mid-square home slot, linear probing, one result each.
// ----------------------------------------------------------------------------
//
//  transfer   ports                 handshake
//  --------   -------------------   -----------------------------------------
//  request    func, key             taken on start && !busy
//  result     status, slot          shown for one cycle while strobe is high
//
//  Timing: the time from a request's transfer to its strobe grows with len
//  (0..10), the decimal digit count of key*key, peeled one digit per cycle by
//  the divide-by-ten loop, and with k (0..9), the number of slots probed before
//  the hit, one slot memory read per cycle.
//  busy falls with the strobe; a new request may be taken in that cycle.
//  Reset empties every slot at once (valid flags); no clearing pass.
//  The receiver cannot stall: each result is shown once and dropped.
//
module midsquare_hash_linear_probe_table
    import msqh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] func,
    input  key_t       key,
    output logic       strobe,
    output logic [2:0] status,
    output slot_t      slot
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_PROBE
    } state_t;

    state_t     state_reg;
    logic [1:0] func_reg;
    key_t       key_reg;
    logic       strobe_reg;
    logic [2:0] status_reg;
    slot_t      slot_reg;

    logic       accept;
    logic       hash_done;
    slot_t      hash_home;
    probe_req_t probe_req;
    probe_rsp_t probe_rsp;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Home slot: square, then peel decimal digits.
    msqh_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (key),
        .done  (hash_done),
        .home  (hash_home)
    );

    // Launch the probe as soon as the home slot is ready.
    assign probe_req.start = (state_reg == S_HASH) && hash_done;
    assign probe_req.func  = func_reg;
    assign probe_req.key   = key_reg;
    assign probe_req.home  = hash_home;

    msqh_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (probe_req),
        .rsp   (probe_rsp)
    );

    // Sequence one request at a time; register the result for its strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg  <= func;
                        key_reg   <= key;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                        state_reg <= S_PROBE;
                end
                S_PROBE:
                begin
                    // hold until the table answers, then present the result
                    if (probe_rsp.done)
                    begin
                        strobe_reg <= 1'b1;
                        status_reg <= probe_rsp.status;
                        slot_reg   <= probe_rsp.slot;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign strobe = strobe_reg;
    assign status = status_reg;
    assign slot   = slot_reg;

endmodule

FILE: rtl/core/msqh_hash.sv
// ----------------------------------------------------------------------------
// msqh_hash
// Decimal mid-square home slot: square, peel one decimal digit per cycle.
// ----------------------------------------------------------------------------
module msqh_hash
    import msqh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  key_t  key,
    output logic  done,
    output slot_t home
);

    typedef enum logic [1:0] {
        H_IDLE,
        H_SQUARE,
        H_DIGIT,
        H_PICK
    } hstate_t;

    hstate_t          state_reg;
    key_t             key_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [3:0]       len_reg;
    logic [3:0]       digit_reg [DIGITS];
    logic             done_reg;
    slot_t            home_reg;

    logic [63:0]      prod;
    logic [28:0]      quot;
    logic [SQ_W-1:0]  rem;
    logic [3:0]       pick_idx;

    // quotient by ten through the reciprocal, remainder by shift-add
    assign prod     = {32'd0, sq_reg} * {32'd0, RECIP10};
    assign quot     = prod[63:35];
    assign rem      = sq_reg - ({quot, 3'b000} + {2'b00, quot, 1'b0});
    assign pick_idx = (len_reg + 4'd1) >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
            len_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                        state_reg <= H_SQUARE;
                end
                H_SQUARE:
                begin
                    len_reg   <= '0;
                    state_reg <= H_DIGIT;
                end
                H_DIGIT:
                begin
                    if (sq_reg == '0)
                        state_reg <= H_PICK;
                    else
                        len_reg <= len_reg + 4'd1;
                end
                H_PICK:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= H_IDLE;
                end
                default:
                    state_reg <= H_IDLE;
            endcase
        end
    end

    // datapath: no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == H_IDLE && start)
            key_reg <= key;
        if (state_reg == H_SQUARE)
            sq_reg <= {16'd0, key_reg} * {16'd0, key_reg};
        if (state_reg == H_DIGIT && sq_reg != '0)
        begin
            sq_reg             <= {3'b000, quot};
            digit_reg[len_reg] <= rem[3:0];
        end
        if (state_reg == H_PICK)
            home_reg <= (len_reg <= 4'd2) ? '0 : digit_reg[pick_idx];
    end

    assign done = done_reg;
    assign home = home_reg;

endmodule

FILE: rtl/core/msqh_table.sv
// ----------------------------------------------------------------------------
// msqh_table
// Slot memory with valid flags; probes one slot per cycle from the home slot.
// ----------------------------------------------------------------------------
module msqh_table
    import msqh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  probe_req_t req,
    output probe_rsp_t rsp
);

    typedef enum logic {
        T_IDLE,
        T_PROBE
    } tstate_t;

    tstate_t          state_reg;
    logic [1:0]       func_reg;
    key_t             key_reg;
    slot_t            addr_reg;
    logic [3:0]       issue_cnt_reg;
    logic             cmp_vld_reg;
    slot_t            cmp_slot_reg;
    logic             cmp_last_reg;
    logic [SLOTS-1:0] valid_reg;
    logic             done_reg;
    logic [2:0]       status_reg;
    slot_t            slot_reg;

    key_t             key_mem [SLOTS];
    key_t             rdata_reg;

    logic             issue_en;
    logic             hit;
    logic             finish;
    logic             wr_en;
    slot_t            addr_inc;

    assign addr_inc = (addr_reg == slot_t'(SLOTS - 1)) ? '0 : addr_reg + slot_t'(1);
    assign issue_en = (state_reg == T_PROBE) && (issue_cnt_reg != 4'(SLOTS));

    always_comb
    begin
        if (func_reg == FN_INSERT)
            hit = cmp_vld_reg && !valid_reg[cmp_slot_reg];
        else
            hit = cmp_vld_reg && valid_reg[cmp_slot_reg] && (rdata_reg == key_reg);
    end

    assign finish = (state_reg == T_PROBE) && cmp_vld_reg && (hit || cmp_last_reg);
    assign wr_en  = finish && hit && (func_reg == FN_INSERT);

    // synchronous slot memory with a registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            key_mem[cmp_slot_reg] <= key_reg;
        rdata_reg <= key_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            issue_cnt_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                T_IDLE:
                begin
                    cmp_vld_reg <= 1'b0;
                    if (req.start)
                    begin
                        func_reg      <= req.func;
                        key_reg       <= req.key;
                        addr_reg      <= req.home;
                        issue_cnt_reg <= '0;
                        state_reg     <= T_PROBE;
                    end
                end
                T_PROBE:
                begin
                    if (finish)
                    begin
                        cmp_vld_reg <= 1'b0;
                        done_reg    <= 1'b1;
                        state_reg   <= T_IDLE;
                        if (!hit)
                        begin
                            status_reg <= (func_reg == FN_INSERT) ? ST_FULL : ST_NOTFOUND;
                            slot_reg   <= '0;
                        end
                        else
                        begin
                            slot_reg <= cmp_slot_reg;
                            case (func_reg)
                                FN_INSERT:
                                begin
                                    status_reg              <= ST_INSERTED;
                                    valid_reg[cmp_slot_reg] <= 1'b1;
                                end
                                FN_DELETE:
                                begin
                                    status_reg              <= ST_DELETED;
                                    valid_reg[cmp_slot_reg] <= 1'b0;
                                end
                                default:
                                    status_reg <= ST_FOUND;
                            endcase
                        end
                    end
                    else if (issue_en)
                    begin
                        cmp_vld_reg   <= 1'b1;
                        cmp_slot_reg  <= addr_reg;
                        cmp_last_reg  <= (issue_cnt_reg == 4'(SLOTS - 1));
                        addr_reg      <= addr_inc;
                        issue_cnt_reg <= issue_cnt_reg + 4'd1;
                    end
                    else
                    begin
                        cmp_vld_reg <= 1'b0;
                    end
                end
                default:
                    state_reg <= T_IDLE;
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.status = status_reg;
    assign rsp.slot   = slot_reg;

endmodule

FILE: rtl/core/msqh_checker.sv
// ----------------------------------------------------------------------------
// msqh_checker
// Port-level checks on request and result transfers of the hash table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msqh_checker
    import msqh_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] func,
    input key_t       key,
    input logic       strobe,
    input logic [2:0] status,
    input slot_t      slot
);

    logic miss;

    assign miss = (status == ST_FULL) || (status == ST_NOTFOUND);

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "request not held busy")
    `ASSERT_IMPLY(a_strobe_idle, clk, rst_n, strobe, !busy, "result while still busy")
    `ASSERT_NEXT(a_strobe_once, clk, rst_n, strobe, !strobe, "result repeated")
    `ASSERT_IMPLY(a_miss_slot, clk, rst_n, strobe && miss, slot == '0, "miss with slot set")
    `ASSERT_IMPLY(a_slot_range, clk, rst_n, strobe, slot < slot_t'(SLOTS), "slot out of range")

endmodule

bind midsquare_hash_linear_probe_table msqh_checker u_msqh_checker (.*);
